### src/igf_pkg.sv
package igf_pkg;

	localparam int MAX_BRUSHES = 64;
	localparam int Z_WIDTH     = 32;
	localparam int IDX_W       = $clog2(MAX_BRUSHES);
	localparam int CNT_W       = $clog2(MAX_BRUSHES + 1);
	localparam int EPS_W       = 12;
	localparam int OUT_IDX_W   = 6;
	localparam int GCNT_W      = 6;
	localparam logic [GCNT_W-1:0] MAX_GAPS = 6'd63;
	localparam logic [EPS_W-1:0]  EPS_RESET = 12'd4;

	localparam logic [2:0] KIND_LIQUID = 3'd2;
	localparam logic [2:0] KIND_RAIL   = 3'd3;
	localparam logic [2:0] KIND_LIGHT  = 3'd4;

	localparam logic [1:0] RA_PREV = 2'd0;
	localparam logic [1:0] RA_ZERO = 2'd1;
	localparam logic [1:0] RA_PTR  = 2'd2;
	localparam logic [1:0] RA_NEXT = 2'd3;

	typedef struct packed {
		logic signed [31:0] bottom_z;
		logic signed [31:0] top_z;
		logic [2:0]         kind;
		logic               last_brush;
	} igf_in_t;

	typedef struct packed {
		logic               gap_valid;
		logic signed [31:0] gap_floor;
		logic signed [31:0] gap_ceiling;
		logic [5:0]         floor_index;
		logic [5:0]         ceiling_index;
		logic               last_gap;
	} igf_out_t;

	typedef struct packed {
		logic signed [Z_WIDTH-1:0] bottom;
		logic signed [Z_WIDTH-1:0] top;
		logic [2:0]                kind;
		logic [IDX_W-1:0]          idx;
	} igf_entry_t;

	typedef struct packed {
		logic       take_item;
		logic       ptr_load_cnt;
		logic       ptr_zero;
		logic       ptr_dec;
		logic       ptr_inc;
		logic       wr_shift;
		logic       wr_place;
		logic [1:0] ra_sel;
		logic       h_load;
		logic       pend_set;
		logic       pend_clr;
		logic       push_pend;
		logic       push_last;
		logic       cnt_inc;
		logic       cnt_clr;
	} igf_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic n_ge2;
		logic in_last;
		logic item_last;
		logic ptr_one;
		logic ins_gt;
		logic eph_h;
		logic eph_a;
		logic gap;
		logic gap_room;
		logic a_higher;
		logic k_last;
		logic pend;
		logic out_free;
	} igf_stat_t;

	function automatic logic is_ephemeral(input logic [2:0] k);
		return (k == KIND_LIQUID) || (k == KIND_RAIL) || (k == KIND_LIGHT);
	endfunction

endpackage

### src/interval_gap_finder.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data (igf_in_t)
// out     | output    | out_valid / out_ready  | out_data (igf_out_t)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (epsilon, 12 bits)
// an item that is not last goes straight to placement in an empty column; otherwise
// each stored interval with a larger bottom z takes a read step and a compare step and
// is shifted up, and the walk stops at the first compare that does not shift or at the
// bottom of the interval memory; a last item then adds a sweep over the stored intervals
// reset clears control only; the interval memory needs no clearing pass
// a full output register stalls the sweep when a gap must be pushed; cfg is always ready
module interval_gap_finder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  igf_pkg::igf_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output igf_pkg::igf_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [11:0]       cfg_data
);
	import igf_pkg::*;

	igf_cmd_t  cmd;
	igf_stat_t st;

	assign cfg_ready = 1'b1;

	igf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	igf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

### src/igf_ctrl.sv
module igf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  igf_pkg::igf_stat_t st,
	output igf_pkg::igf_cmd_t  cmd
);
	import igf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INSRD = 3'd1;
	localparam logic [2:0] S_INSCM = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_SWST  = 3'd4;
	localparam logic [2:0] S_SWH   = 3'd5;
	localparam logic [2:0] S_SWEV  = 3'd6;
	localparam logic [2:0] S_SWEND = 3'd7;

	logic [2:0] state_q, state_d;
	logic       advance;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.ra_sel = RA_PTR;
		state_d = state_q;
		advance = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (!st.cnt_full) begin
						cmd.ptr_load_cnt = 1'b1;
						state_d = st.cnt_zero ? S_PLACE : S_INSRD;
					end else if (st.in_last) begin
						state_d = st.n_ge2 ? S_SWST : S_SWEND;
					end
				end
			end
			S_INSRD: begin
				cmd.ra_sel = RA_PREV;
				state_d = S_INSCM;
			end
			S_INSCM: begin
				if (st.ins_gt) begin
					cmd.wr_shift = 1'b1;
					cmd.ptr_dec  = 1'b1;
					state_d = st.ptr_one ? S_PLACE : S_INSRD;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.wr_place = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (st.item_last) begin
					// count before this item: zero means this item is the only one, so no sweep is needed
					state_d = st.cnt_zero ? S_SWEND : S_SWST;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SWST: begin
				cmd.ra_sel   = RA_ZERO;
				cmd.ptr_zero = 1'b1;
				state_d = S_SWH;
			end
			S_SWH: begin
				cmd.h_load  = 1'b1;
				cmd.ra_sel  = RA_NEXT;
				cmd.ptr_inc = 1'b1;
				state_d = S_SWEV;
			end
			S_SWEV: begin
				if (st.eph_h) begin
					cmd.h_load = 1'b1;
					advance = 1'b1;
				end else if (st.eph_a) begin
					advance = 1'b1;
				end else if (st.gap) begin
					if (!st.gap_room) begin
						cmd.h_load = 1'b1;
						advance = 1'b1;
					end else if (!st.pend || st.out_free) begin
						cmd.push_pend = st.pend;
						cmd.pend_set  = 1'b1;
						cmd.h_load    = 1'b1;
						advance = 1'b1;
					end
					// otherwise hold: previous gap still waits for the output
				end else begin
					cmd.h_load = st.a_higher;
					advance = 1'b1;
				end
				if (advance) begin
					if (st.k_last) begin
						state_d = S_SWEND;
					end else begin
						cmd.ra_sel  = RA_NEXT;
						cmd.ptr_inc = 1'b1;
					end
				end
			end
			S_SWEND: begin
				if (st.out_free) begin
					cmd.push_last = 1'b1;
					cmd.pend_clr  = 1'b1;
					cmd.cnt_clr   = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### src/igf_dp.sv
module igf_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  igf_pkg::igf_in_t      in_data,
	input  logic                  cfg_valid,
	input  logic [11:0]           cfg_data,
	output igf_pkg::igf_out_t     out_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  igf_pkg::igf_cmd_t     cmd,
	output igf_pkg::igf_stat_t    st
);
	import igf_pkg::*;

	igf_entry_t mem [MAX_BRUSHES];
	igf_entry_t rd_q, h_q, new_q;
	logic [IDX_W-1:0] ptr_q, ra, wa;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic [EPS_W-1:0] eps_q;
	logic             pend_q;
	logic signed [31:0] pf_q, pc_q;
	logic [OUT_IDX_W-1:0] pfi_q, pci_q;
	logic [GCNT_W-1:0] gcnt_q;
	logic             out_valid_q;
	igf_out_t         out_q;
	logic signed [Z_WIDTH+1:0] thr, bot_ext;
	logic             we;
	igf_entry_t       wd;

	always_comb begin
		case (cmd.ra_sel)
			RA_PREV: ra = ptr_q - 1'b1;
			RA_ZERO: ra = '0;
			RA_NEXT: ra = ptr_q + 1'b1;
			default: ra = ptr_q;
		endcase
	end

	assign we = cmd.wr_shift | cmd.wr_place;
	assign wa = ptr_q;
	assign wd = cmd.wr_shift ? rd_q : new_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			new_q.bottom <= in_data.bottom_z;
			new_q.top    <= in_data.top_z;
			new_q.kind   <= in_data.kind;
			new_q.idx    <= cnt_q[IDX_W-1:0];
			last_q       <= in_data.last_brush;
		end
		if (cmd.h_load) begin
			h_q <= rd_q;
		end
		if (cmd.pend_set) begin
			pf_q  <= h_q.top;
			pc_q  <= rd_q.bottom;
			pfi_q <= OUT_IDX_W'(h_q.idx);
			pci_q <= OUT_IDX_W'(rd_q.idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			eps_q  <= EPS_RESET;
			pend_q <= 1'b0;
			gcnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				eps_q <= cfg_data;
			end
			if (cmd.ptr_load_cnt) begin
				ptr_q <= cnt_q[IDX_W-1:0];
			end else if (cmd.ptr_zero) begin
				ptr_q <= '0;
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.pend_clr) begin
				pend_q <= 1'b0;
				gcnt_q <= '0;
			end else if (cmd.pend_set) begin
				pend_q <= 1'b1;
				gcnt_q <= gcnt_q + 1'b1;
			end
		end
	end

	// output register, refilled in the same cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_pend | cmd.push_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_pend | (cmd.push_last & pend_q)) begin
			out_q <= '{gap_valid: 1'b1, gap_floor: pf_q, gap_ceiling: pc_q,
				floor_index: pfi_q, ceiling_index: pci_q, last_gap: cmd.push_last};
		end else if (cmd.push_last) begin
			out_q <= '{gap_valid: 1'b0, gap_floor: '0, gap_ceiling: '0,
				floor_index: '0, ceiling_index: '0, last_gap: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign bot_ext = (Z_WIDTH+2)'(rd_q.bottom);
	assign thr     = (Z_WIDTH+2)'(h_q.top) + $signed({{(Z_WIDTH+2-EPS_W){1'b0}}, eps_q});

	always_comb begin
		st.cnt_zero  = (cnt_q == '0);
		st.cnt_full  = (cnt_q == CNT_W'(MAX_BRUSHES));
		st.n_ge2     = (cnt_q >= CNT_W'(2));
		st.in_last   = in_data.last_brush;
		st.item_last = last_q;
		st.ptr_one   = (ptr_q == IDX_W'(1));
		st.ins_gt    = (rd_q.bottom > new_q.bottom);
		st.eph_h     = is_ephemeral(h_q.kind);
		st.eph_a     = is_ephemeral(rd_q.kind);
		st.gap       = (bot_ext > thr);
		st.gap_room  = (gcnt_q != MAX_GAPS);
		st.a_higher  = (rd_q.top > h_q.top);
		st.k_last    = ((CNT_W'(ptr_q) + 1'b1) == cnt_q);
		st.pend      = pend_q;
		st.out_free  = !out_valid_q || out_ready;
	end

endmodule

### src/igf_checker.sv
module igf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input igf_pkg::igf_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input igf_pkg::igf_out_t out_data
);
	import igf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out transfer dropped or changed while stalled");

	// a closing transfer always starts an insertion walk, a placement or a sweep
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_brush |=> !in_ready)
		else $error("input ready right after a closing transfer");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.gap_valid |-> out_data.last_gap)
		else $error("empty result not flagged last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.gap_valid |-> out_data.gap_floor == '0 &&
		out_data.gap_ceiling == '0 && out_data.floor_index == '0 &&
		out_data.ceiling_index == '0)
		else $error("empty result carries data");

endmodule

bind interval_gap_finder igf_checker u_igf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
